// ===== design/lznm_pkg.sv =====
// shared widths and reset constants for the lz77 nearest-match encoder
// no dependencies; used by the cell row and the top level
package lznm_pkg;

  localparam int ByteW          = 8;
  localparam int CfgW           = 7;
  localparam int WindowDepthDef = 64;
  localparam int MaxExtDef      = 10;

  localparam logic [CfgW-1:0] WindowLenReset = CfgW'(64);

endpackage

// ===== design/lznm_cell.sv =====
// one window cell: holds a history byte, shifts it to the older neighbor
// and compares it with the incoming byte; uses lznm_pkg
module lznm_cell (
  input  logic                      clk_i,
  input  logic                      shift_i,
  input  logic [lznm_pkg::ByteW-1:0] prev_byte_i,
  input  logic [lznm_pkg::ByteW-1:0] in_byte_i,
  input  logic                      valid_i,
  input  logic                      sel_i,
  output logic [lznm_pkg::ByteW-1:0] byte_o,
  output logic                      hit_o,
  output logic                      follow_o
);

  logic [lznm_pkg::ByteW-1:0] byte_q;
  logic                       eq;

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      byte_q <= prev_byte_i;
    end
  end

  assign eq       = (byte_q == in_byte_i);
  assign hit_o    = eq & valid_i;
  assign follow_o = eq & sel_i;
  assign byte_o   = byte_q;

endmodule

// ===== design/lznm_first_hit.sv =====
// finds the newest window cell that matches the incoming byte
// no package dependencies
module lznm_first_hit #(
  parameter int N = 64
) (
  input  logic [N-1:0]         hit_i,
  output logic                 found_o,
  output logic [$clog2(N)-1:0] pos_o
);

  always_comb begin
    pos_o = '0;
    // walk from oldest to newest so the newest hit wins
    for (int i = N - 1; i >= 0; i--) begin
      if (hit_i[i]) begin
        pos_o = ($clog2(N))'(i);
      end
    end
  end

  assign found_o = |hit_i;

endmodule

// ===== design/lz77_nearest_match_encoder.sv =====
// Greedy LZ77 encoder: one byte request per clock, one token out per match or literal.
// A byte is taken every cycle unless a token waits in the output register while the
// receiver stalls. The search compares the byte against every window cell at once and a
// priority encoder picks the newest hit; the token of a byte, if any,
// shows in the output register on the next cycle. The window is a shift row of
// WINDOW_DEPTH cells. window_length may only be written while the block is idle.
// Depends on lznm_pkg, lznm_cell and lznm_first_hit.
module lz77_nearest_match_encoder #(
  parameter int WINDOW_DEPTH   = lznm_pkg::WindowDepthDef,
  parameter int MAX_EXTENSIONS = lznm_pkg::MaxExtDef,
  localparam int PosW  = $clog2(WINDOW_DEPTH),
  localparam int LenW  = $clog2(MAX_EXTENSIONS + 2),
  localparam int FillW = $clog2(WINDOW_DEPTH + 1)
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [lznm_pkg::CfgW-1:0]  cfg_wdata_i,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [lznm_pkg::ByteW-1:0] in_byte_i,
  input  logic                       last_byte_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [PosW-1:0]            match_position_o,
  output logic [LenW-1:0]            match_length_o,
  output logic [lznm_pkg::ByteW-1:0] next_byte_o,
  output logic                       has_next_byte_o,
  output logic                       final_token_o
);

  logic [lznm_pkg::CfgW-1:0] win_len_q;
  logic [FillW-1:0]          fill_q, fill_d, eff_len;
  logic                      running_q, running_d;
  logic [PosW-1:0]           dist_q, dist_d;
  logic [LenW-1:0]           count_q, count_d;

  logic                       out_valid_q;
  logic [PosW-1:0]            pos_q, pos_d;
  logic [LenW-1:0]            len_q, len_d;
  logic [lznm_pkg::ByteW-1:0] nb_q, nb_d;
  logic                       has_nb_q, has_nb_d;
  logic                       fin_q, fin_d;
  logic                       produce;

  logic                       accept;
  logic [WINDOW_DEPTH-1:0]    hit, follow;
  logic [lznm_pkg::ByteW-1:0] cell_byte [WINDOW_DEPTH];
  logic                       found;
  logic [PosW-1:0]            found_pos;
  logic                       match_grows;

  assign in_stall_o = out_valid_q & out_stall_i;
  assign accept     = in_valid_i & ~in_stall_o;

  // cell row, newest byte at index 0
  for (genvar k = 0; k < WINDOW_DEPTH; k++) begin : g_cell
    logic [lznm_pkg::ByteW-1:0] prev_byte;
    if (k == 0) begin : g_head
      assign prev_byte = in_byte_i;
    end else begin : g_body
      assign prev_byte = cell_byte[k-1];
    end
    lznm_cell u_cell (
      .clk_i      (clk_i),
      .shift_i    (accept),
      .prev_byte_i(prev_byte),
      .in_byte_i  (in_byte_i),
      .valid_i    (FillW'(k) < fill_q),
      .sel_i      (dist_q == PosW'(k)),
      .byte_o     (cell_byte[k]),
      .hit_o      (hit[k]),
      .follow_o   (follow[k])
    );
  end

  lznm_first_hit #(
    .N(WINDOW_DEPTH)
  ) u_first_hit (
    .hit_i  (hit),
    .found_o(found),
    .pos_o  (found_pos)
  );

  // window length saturated to 1..WINDOW_DEPTH
  always_comb begin
    if (win_len_q == '0) begin
      eff_len = FillW'(1);
    end else if (int'(win_len_q) > WINDOW_DEPTH) begin
      eff_len = FillW'(WINDOW_DEPTH);
    end else begin
      eff_len = FillW'(win_len_q);
    end
  end

  assign match_grows = (|follow) && (count_q < LenW'(MAX_EXTENSIONS + 1));

  always_comb begin
    running_d = running_q;
    dist_d    = dist_q;
    count_d   = count_q;
    fill_d    = fill_q;
    produce   = 1'b0;
    pos_d     = pos_q;
    len_d     = len_q;
    nb_d      = nb_q;
    has_nb_d  = has_nb_q;
    fin_d     = fin_q;
    if (accept) begin
      fill_d = (fill_q < eff_len) ? fill_q + FillW'(1) : eff_len;
      if (running_q) begin
        if (match_grows) begin
          count_d = count_q + LenW'(1);
          if (last_byte_i) begin
            produce   = 1'b1;
            pos_d     = dist_q;
            len_d     = count_q + LenW'(1);
            nb_d      = '0;
            has_nb_d  = 1'b0;
            fin_d     = 1'b1;
            running_d = 1'b0;
          end
        end else begin
          produce   = 1'b1;
          pos_d     = dist_q;
          len_d     = count_q;
          nb_d      = in_byte_i;
          has_nb_d  = 1'b1;
          fin_d     = last_byte_i;
          running_d = 1'b0;
        end
      end else if (!found) begin
        produce  = 1'b1;
        pos_d    = '0;
        len_d    = '0;
        nb_d     = in_byte_i;
        has_nb_d = 1'b1;
        fin_d    = last_byte_i;
      end else if (last_byte_i) begin
        produce  = 1'b1;
        pos_d    = found_pos;
        len_d    = LenW'(1);
        nb_d     = '0;
        has_nb_d = 1'b0;
        fin_d    = 1'b1;
      end else begin
        running_d = 1'b1;
        dist_d    = found_pos;
        count_d   = LenW'(1);
      end
      // end of stream starts a fresh window
      if (last_byte_i) begin
        running_d = 1'b0;
        dist_d    = '0;
        count_d   = '0;
        fill_d    = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_len_q   <= lznm_pkg::WindowLenReset;
      fill_q      <= '0;
      running_q   <= 1'b0;
      dist_q      <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        win_len_q <= cfg_wdata_i;
      end
      fill_q    <= fill_d;
      running_q <= running_d;
      dist_q    <= dist_d;
      count_q   <= count_d;
      if (produce) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (produce) begin
      pos_q    <= pos_d;
      len_q    <= len_d;
      nb_q     <= nb_d;
      has_nb_q <= has_nb_d;
      fin_q    <= fin_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign match_position_o = pos_q;
  assign match_length_o   = len_q;
  assign next_byte_o      = nb_q;
  assign has_next_byte_o  = has_nb_q;
  assign final_token_o    = fin_q;

endmodule

// ===== tb/lznm_token_checker.sv =====
`timescale 1ns / 1ps
// token checker for the lz77 nearest-match encoder: tracks the window and match state,
// predicts the token of each byte request and compares every token that leaves the block
// depends on lznm_pkg
module lznm_token_checker #(
  parameter int WINDOW_DEPTH   = lznm_pkg::WindowDepthDef,
  parameter int MAX_EXTENSIONS = lznm_pkg::MaxExtDef,
  localparam int PosW = $clog2(WINDOW_DEPTH),
  localparam int LenW = $clog2(MAX_EXTENSIONS + 2)
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [lznm_pkg::CfgW-1:0]  cfg_wdata_i,
  input  logic                       in_valid_i,
  input  logic                       in_stall_i,
  input  logic [lznm_pkg::ByteW-1:0] in_byte_i,
  input  logic                       last_byte_i,
  input  logic                       out_valid_i,
  input  logic                       out_stall_i,
  input  logic [PosW-1:0]            match_position_i,
  input  logic [LenW-1:0]            match_length_i,
  input  logic [lznm_pkg::ByteW-1:0] next_byte_i,
  input  logic                       has_next_byte_i,
  input  logic                       final_token_i,
  output int                         fail_count_o,
  output int                         pending_o
);

  typedef struct packed {
    logic [PosW-1:0] position;
    logic [LenW-1:0] length;
    logic [7:0]      follow_byte;
    logic            has_follow;
    logic            ends_stream;
  } lz_token_t;

  logic [7:0]               window_bytes [WINDOW_DEPTH];
  logic [lznm_pkg::CfgW-1:0] window_len_cfg = lznm_pkg::WindowLenReset;
  int unsigned              window_fill = 0;
  logic                     match_open = 1'b0;
  int unsigned              match_pos = 0;
  int unsigned              match_len = 0;
  int unsigned              match_dist = 0;
  lz_token_t                expected_tokens [$];
  int                       mismatches = 0;

  assign fail_count_o = mismatches;

  function automatic int unsigned effective_len();
    int unsigned w;
    w = window_len_cfg;
    if (w < 1) w = 1;
    if (w > WINDOW_DEPTH) w = WINDOW_DEPTH;
    return w;
  endfunction

  function automatic void shift_in(logic [7:0] b);
    int unsigned w;
    w = effective_len();
    for (int i = WINDOW_DEPTH - 1; i > 0; i--) window_bytes[i] = window_bytes[i-1];
    window_bytes[0] = b;
    if (window_fill < w) window_fill++;
    if (window_fill > w) window_fill = w;
  endfunction

  function automatic void queue_token(int unsigned pos, int unsigned len, logic [7:0] fb,
                                      logic has_fb, logic ends);
    lz_token_t tok;
    tok.position    = PosW'(pos);
    tok.length      = LenW'(len);
    tok.follow_byte = fb;
    tok.has_follow  = has_fb;
    tok.ends_stream = ends;
    expected_tokens.push_back(tok);
  endfunction

  function automatic void encode_byte(logic [7:0] b, logic lst);
    logic        grows;
    logic        hit;
    int unsigned hit_pos;
    hit     = 1'b0;
    hit_pos = 0;
    if (match_open) begin
      grows = (match_dist < WINDOW_DEPTH) && (match_len < MAX_EXTENSIONS + 1) &&
              (window_bytes[match_dist] == b);
      shift_in(b);
      if (grows) begin
        match_len++;
        if (lst) begin
          queue_token(match_pos, match_len, 8'h00, 1'b0, 1'b1);
          match_open = 1'b0;
        end
      end else begin
        queue_token(match_pos, match_len, b, 1'b1, lst);
        match_open = 1'b0;
      end
    end else begin
      // newest hit wins
      for (int i = 0; i < window_fill && i < WINDOW_DEPTH; i++) begin
        if (!hit && window_bytes[i] == b) begin
          hit     = 1'b1;
          hit_pos = i;
        end
      end
      shift_in(b);
      if (!hit) begin
        queue_token(0, 0, b, 1'b1, lst);
      end else if (lst) begin
        queue_token(hit_pos, 1, 8'h00, 1'b0, 1'b1);
      end else begin
        match_open = 1'b1;
        match_pos  = hit_pos % (1 << PosW);
        match_dist = hit_pos;
        match_len  = 1;
      end
    end
    // end of stream clears match and window
    if (lst) begin
      match_open  = 1'b0;
      match_pos   = 0;
      match_len   = 0;
      match_dist  = 0;
      window_fill = 0;
    end
  endfunction

  function automatic void check_field(string field, logic [7:0] want, logic [7:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch_channels
    lz_token_t tok;
    if (!rst_ni) begin
      expected_tokens.delete();
      window_len_cfg = lznm_pkg::WindowLenReset;
      window_fill    = 0;
      match_open     = 1'b0;
      match_pos      = 0;
      match_len      = 0;
      match_dist     = 0;
      pending_o     <= 0;
    end else begin
      // a token leaving now always belongs to an earlier request
      if (out_valid_i && !out_stall_i) begin
        if (expected_tokens.size() == 0) begin
          $display("%0t: unexpected token, expected none, got pos %0d len %0d byte %0d",
                   $time, match_position_i, match_length_i, next_byte_i);
          mismatches++;
        end else begin
          tok = expected_tokens.pop_front();
          check_field("match_position", 8'(tok.position), 8'(match_position_i));
          check_field("match_length", 8'(tok.length), 8'(match_length_i));
          check_field("next_byte", tok.follow_byte, next_byte_i);
          check_field("has_next_byte", 8'(tok.has_follow), 8'(has_next_byte_i));
          check_field("final_token", 8'(tok.ends_stream), 8'(final_token_i));
        end
      end
      if (in_valid_i && !in_stall_i) encode_byte(in_byte_i, last_byte_i);
      if (cfg_we_i) window_len_cfg = cfg_wdata_i;
      pending_o <= expected_tokens.size();
    end
  end

endmodule

// ===== tb/lz77_nearest_match_encoder_test.sv =====
`timescale 1ns / 1ps
// top of the lz77 nearest-match encoder test: clock, reset, byte requests, window settings
// and receiver stalls; depends on lznm_pkg, the encoder and lznm_token_checker
module lz77_nearest_match_encoder_test;

  localparam int PosW        = $clog2(lznm_pkg::WindowDepthDef);
  localparam int LenW        = $clog2(lznm_pkg::MaxExtDef + 2);
  localparam int QuietLimit  = 2000;
  localparam int PhaseItems  = 100;
  localparam int Phases      = 11;

  logic                       clk_i = 1'b0;
  logic                       rst_ni;
  logic                       cfg_we_i;
  logic [lznm_pkg::CfgW-1:0]  cfg_wdata_i;
  logic                       in_valid_i;
  logic                       in_stall_o;
  logic [lznm_pkg::ByteW-1:0] in_byte_i;
  logic                       last_byte_i;
  logic                       out_valid_o;
  logic                       out_stall_i;
  logic [PosW-1:0]            match_position_o;
  logic [LenW-1:0]            match_length_o;
  logic [lznm_pkg::ByteW-1:0] next_byte_o;
  logic                       has_next_byte_o;
  logic                       final_token_o;
  int                         fail_count;
  int                         pending;
  logic                       hold_off_req = 1'b0;
  int                         burst_left = 0;
  logic [7:0]                 recent [$];

  always #10 clk_i = ~clk_i;

  lz77_nearest_match_encoder DUT (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .in_byte_i        (in_byte_i),
    .last_byte_i      (last_byte_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .match_position_o (match_position_o),
    .match_length_o   (match_length_o),
    .next_byte_o      (next_byte_o),
    .has_next_byte_o  (has_next_byte_o),
    .final_token_o    (final_token_o)
  );

  lznm_token_checker u_token_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .in_valid_i       (in_valid_i),
    .in_stall_i       (in_stall_o),
    .in_byte_i        (in_byte_i),
    .last_byte_i      (last_byte_i),
    .out_valid_i      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .match_position_i (match_position_o),
    .match_length_i   (match_length_o),
    .next_byte_i      (next_byte_o),
    .has_next_byte_i  (has_next_byte_o),
    .final_token_i    (final_token_o),
    .fail_count_o     (fail_count),
    .pending_o        (pending)
  );

  // sender works in bursts; a gap of zero keeps valid high across bursts
  task automatic send_byte(input logic [7:0] b, input logic lst);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    in_valid_i  <= 1'b1;
    in_byte_i   <= b;
    last_byte_i <= lst;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    burst_left--;
    recent.push_back(b);
    if (recent.size() > 80) void'(recent.pop_front());
    if (lst) recent.delete();
  endtask

  // drop valid, then wait for every expected token to leave
  task automatic settle();
    in_valid_i <= 1'b0;
    burst_left = 0;
    do @(negedge clk_i); while (pending != 0);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic set_window_length(input logic [lznm_pkg::CfgW-1:0] len);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= len;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  initial begin : receiver
    int   mode;
    int   mode_left;
    logic hold_served;
    mode        = 0;
    mode_left   = 0;
    hold_served = 1'b0;
    out_stall_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      // long hold-off so the output register fills and the input backs up
      if (hold_off_req && !hold_served) begin
        hold_served = 1'b1;
        out_stall_i <= 1'b1;
        repeat (300) @(posedge clk_i);
      end
      if (mode_left == 0) begin
        mode      = $urandom_range(0, 2);
        mode_left = $urandom_range(10, 80);
      end
      mode_left--;
      case (mode)
        0: begin
          out_stall_i <= 1'b0;
        end
        1: begin
          out_stall_i <= ($urandom_range(0, 2) == 0);
        end
        default: begin
          out_stall_i <= ((mode_left % 5) < 2);
        end
      endcase
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QuietLimit) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet = 0;
      else quiet++;
    end
    $display("*** FAILED ***");
    $finish;
  end

  initial begin : stimulus
    logic [8:0]                opening [$];
    logic [7:0]                run_bytes [$];
    logic [lznm_pkg::CfgW-1:0] window_settings [Phases];
    logic [lznm_pkg::CfgW-1:0] setting;
    logic [7:0]                b;
    int                        sent;
    int                        pick;
    int                        replay_back;
    int                        run;
    rst_ni      <= 1'b0;
    cfg_we_i    <= 1'b0;
    cfg_wdata_i <= '0;
    in_valid_i  <= 1'b0;
    in_byte_i   <= '0;
    last_byte_i <= 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // {last, byte}: extreme bytes, a match ended by a literal, a run to the length cap,
    // end of stream on an empty window and inside an extending match
    opening = '{9'h000, 9'h0ff, 9'h000, 9'h0ff, 9'h15a,
                9'h041, 9'h041, 9'h041, 9'h041, 9'h041, 9'h041, 9'h041,
                9'h041, 9'h041, 9'h041, 9'h041, 9'h041, 9'h041, 9'h141,
                9'h17e, 9'h010, 9'h020, 9'h010, 9'h120,
                9'h033, 9'h044, 9'h055, 9'h033};
    foreach (opening[k]) send_byte(opening[k][7:0], opening[k][8]);
    // shrink the window while a match is open, then finish the match at end of stream
    settle();
    set_window_length(2);
    send_byte(8'h44, 1'b0);
    send_byte(8'h55, 1'b1);
    settle();

    window_settings = '{7'd1, 7'd0, 7'd127, 7'd64, 7'd65, 7'd2,
                        7'd3, 7'd8, 7'd16, 7'd40, 7'd64};
    for (int ph = 0; ph < Phases; ph++) begin
      setting = (ph == 9) ? 7'($urandom_range(0, 127)) : window_settings[ph];
      set_window_length(setting);
      if (ph == 2) hold_off_req = 1'b1;
      sent = 0;
      while (sent < PhaseItems) begin
        pick = $urandom_range(0, 9);
        if (pick < 3 && recent.size() > 1) begin
          // replay earlier bytes so matches run long, overlapping copies included
          replay_back = $urandom_range(1, recent.size());
          run         = $urandom_range(1, 14);
          run_bytes.delete();
          for (int k = 0; k < run; k++) begin
            run_bytes.push_back(recent[recent.size() - replay_back + (k % replay_back)]);
          end
          foreach (run_bytes[k]) send_byte(run_bytes[k], 1'b0);
          sent += run;
        end else begin
          b = (pick < 7) ? 8'(8'h61 + $urandom_range(0, 3)) : 8'($urandom_range(0, 255));
          send_byte(b, $urandom_range(0, 59) == 0);
          sent++;
        end
      end
      if ($urandom_range(0, 1) == 1) send_byte(8'($urandom_range(0, 255)), 1'b1);
      settle();
    end

    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== lz77_nearest_match_encoder.f =====
design/lznm_pkg.sv
design/lznm_cell.sv
design/lznm_first_hit.sv
design/lz77_nearest_match_encoder.sv
tb/lznm_token_checker.sv
tb/lz77_nearest_match_encoder_test.sv
